@@ hdl/ils_pkg.sv @@
// shared types and command codes for the indexed list store
package ils_pkg;

   typedef enum logic [1:0] {
      CMD_READ      = 2'd0,
      CMD_OVERWRITE = 2'd1,
      CMD_INSERT    = 2'd2,
      CMD_REMOVE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_ACT,
      ST_LINK,
      ST_RESP
   } state_type;

   // datapath commands issued by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,      // write free stack entry at clear counter
      OP_CAPTURE,    // latch request word
      OP_CHECK,      // range checks, set up walk
      OP_WALK_STEP,  // follow one link
      OP_ACT_RD,     // read links, value and free stack top at located slot
      OP_ACT,        // main write and pointer updates
      OP_LINK        // second relink write, load response
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_done;
   } dp_status_type;

endpackage

@@ hdl/ils_datapath.sv @@
// slot memories, free stack, list pointers and the position walker
module ils_datapath #(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ils_pkg::ctl_cmd_type   ctl,
   output ils_pkg::dp_status_type status,
   input  logic [1:0]             req_cmd,
   input  logic [8:0]             req_position,
   input  logic signed [31:0]     req_data_value,
   output logic                   rsp_ok,
   output logic signed [31:0]     rsp_read_value,
   output logic [8:0]             rsp_count
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   // positions are compared at the wider of the port and count widths
   localparam int XW = (CW > 9) ? CW : 9;

   logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
   logic [AW-1:0]          nxt_mem [CAPACITY];
   logic [AW-1:0]          prv_mem [CAPACITY];
   logic [AW-1:0]          free_mem [CAPACITY];

   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in, free_top_ff, free_top_in;
   logic [CW-1:0] clr_ff, clr_in;

   ils_pkg::cmd_type       cmd_ff;
   logic [XW-1:0]          pos_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic                   ok_ff;
   logic                   mid_ff;
   logic                   dir_fwd_ff;
   logic [CW-1:0]          steps_ff;
   logic [AW-1:0]          cur_ff;

   logic [AW-1:0]          nxt_rd_ff, prv_rd_ff, free_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;

   logic                   rsp_ok_ff;
   logic signed [31:0]     rsp_val_ff;
   logic [8:0]             rsp_cnt_ff;

   logic [XW-1:0] cnt_x;
   logic          is_ins, in_range, ins_ok, ins_mid, rm_mid, need_walk, fwd;
   logic [CW-1:0] tgt_w, half_w, steps_w;
   logic [AW-1:0] start_w;

   assign cnt_x     = XW'(count_ff);
   assign is_ins    = (cmd_ff == ils_pkg::CMD_INSERT);
   assign in_range  = (pos_ff < cnt_x);
   assign ins_ok    = (pos_ff <= cnt_x) && (count_ff < CW'(CAPACITY));
   assign ins_mid   = (count_ff != '0) && (pos_ff != '0) && (pos_ff != cnt_x);
   assign rm_mid    = (count_ff != CW'(1)) && (pos_ff != '0) && (pos_ff != cnt_x - XW'(1));
   assign need_walk = is_ins ? (ins_ok && ins_mid) : in_range;
   // an interior insert locates the slot before the position
   assign tgt_w     = is_ins ? CW'(pos_ff) - CW'(1) : CW'(pos_ff);
   assign half_w    = count_ff >> 1;
   assign fwd       = (tgt_w < half_w);
   assign start_w   = fwd ? head_ff : tail_ff;
   assign steps_w   = !need_walk ? '0 : (fwd ? tgt_w : count_ff - CW'(1) - tgt_w);

   always_comb begin
      status.clear_done = (clr_ff == CW'(CAPACITY - 1));
      status.walk_done  = (steps_ff == '0);
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      free_top_in = free_top_ff;
      clr_in      = clr_ff;
      case (ctl.op)
         ils_pkg::OP_CLEAR: clr_in = clr_ff + CW'(1);
         ils_pkg::OP_ACT: begin
            if (ok_ff) begin
               if (cmd_ff == ils_pkg::CMD_INSERT) begin
                  free_top_in = free_top_ff - CW'(1);
                  count_in    = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     head_in = free_rd_ff;
                     tail_in = free_rd_ff;
                  end else if (pos_ff == '0) begin
                     head_in = free_rd_ff;
                  end else if (pos_ff == cnt_x) begin
                     tail_in = free_rd_ff;
                  end
               end else if (cmd_ff == ils_pkg::CMD_REMOVE) begin
                  free_top_in = free_top_ff + CW'(1);
                  count_in    = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else if (pos_ff == '0) begin
                     head_in = nxt_rd_ff;
                  end else if (pos_ff == cnt_x - XW'(1)) begin
                     tail_in = prv_rd_ff;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         free_top_ff <= CW'(CAPACITY);
         clr_ff      <= '0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         free_top_ff <= free_top_in;
         clr_ff      <= clr_in;
      end
   end

   // request capture, walker and memory ports
   always_ff @(posedge clock) begin
      case (ctl.op)
         ils_pkg::OP_CLEAR: free_mem[clr_ff[AW-1:0]] <= clr_ff[AW-1:0];
         ils_pkg::OP_CAPTURE: begin
            cmd_ff <= ils_pkg::cmd_type'(req_cmd);
            pos_ff <= XW'(req_position);
            val_ff <= VALUE_WIDTH'(req_data_value);
         end
         ils_pkg::OP_CHECK: begin
            ok_ff      <= is_ins ? ins_ok : in_range;
            mid_ff     <= is_ins && ins_mid;
            dir_fwd_ff <= fwd;
            cur_ff     <= start_w;
            steps_ff   <= steps_w;
         end
         ils_pkg::OP_WALK_STEP: begin
            cur_ff   <= dir_fwd_ff ? nxt_mem[cur_ff] : prv_mem[cur_ff];
            steps_ff <= steps_ff - CW'(1);
         end
         ils_pkg::OP_ACT_RD: begin
            nxt_rd_ff  <= nxt_mem[cur_ff];
            prv_rd_ff  <= prv_mem[cur_ff];
            val_rd_ff  <= val_mem[cur_ff];
            free_rd_ff <= free_mem[AW'(free_top_ff - CW'(1))];
         end
         ils_pkg::OP_ACT: begin
            if (ok_ff) begin
               case (cmd_ff)
                  ils_pkg::CMD_OVERWRITE: val_mem[cur_ff] <= val_ff;
                  ils_pkg::CMD_INSERT: begin
                     val_mem[free_rd_ff] <= val_ff;
                     if (count_ff == '0) begin
                        nxt_mem[free_rd_ff] <= '0;
                        prv_mem[free_rd_ff] <= '0;
                     end else if (pos_ff == '0) begin
                        nxt_mem[free_rd_ff] <= head_ff;
                        prv_mem[head_ff]    <= free_rd_ff;
                     end else if (pos_ff == cnt_x) begin
                        nxt_mem[tail_ff]    <= free_rd_ff;
                        prv_mem[free_rd_ff] <= tail_ff;
                     end else begin
                        nxt_mem[free_rd_ff] <= nxt_rd_ff;
                        prv_mem[free_rd_ff] <= cur_ff;
                     end
                  end
                  ils_pkg::CMD_REMOVE: begin
                     free_mem[AW'(free_top_ff)] <= cur_ff;
                     if (rm_mid) begin
                        prv_mem[nxt_rd_ff] <= prv_rd_ff;
                        nxt_mem[prv_rd_ff] <= nxt_rd_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ils_pkg::OP_LINK: begin
            // interior insert: hook the new slot into its neighbors
            if (ok_ff && mid_ff) begin
               nxt_mem[cur_ff]    <= free_rd_ff;
               prv_mem[nxt_rd_ff] <= free_rd_ff;
            end
            rsp_cnt_ff <= 9'(count_ff);
            if (ok_ff && cmd_ff == ils_pkg::CMD_READ)
               rsp_val_ff <= 32'(signed'(val_rd_ff));
            else
               rsp_val_ff <= '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ok_ff <= 1'b0;
      end else if (ctl.op == ils_pkg::OP_LINK) begin
         rsp_ok_ff <= ok_ff;
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_val_ff;
   assign rsp_count      = rsp_cnt_ff;
endmodule

@@ hdl/indexed_list_store.sv @@
// top level and control state machine of the indexed list store
//
// bounded doubly linked list of up to CAPACITY values, one command per word
// request channel req_valid/req_ready carries req_cmd, req_position and
// req_data_value; response channel rsp_valid/rsp_ready carries rsp_ok,
// rsp_read_value and rsp_count, one response word per request word
// after reset a clearing pass loads the free slot stack; req_ready stays
// low until it is done and the list starts out empty
// one word is in flight at a time: req_ready is high only while idle
// each request passes through check, a walk of k links from the nearer end
// (k from 0 to CAPACITY/2 - 1), act read, act and link before rsp_valid
// the next request can be taken in the cycle after the response is
// accepted; a new word is not taken before the last one is through
// when the receiver stalls the response word holds steady and no new
// request is accepted until it is taken
module indexed_list_store #(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [8:0]         req_position,
   input  logic signed [31:0] req_data_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic signed [31:0] rsp_read_value,
   output logic [8:0]         rsp_count
);
   ils_pkg::ctl_cmd_type   ctl;
   ils_pkg::dp_status_type status;

   ils_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   ils_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .status         (status),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_data_value (req_data_value),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );
endmodule

module ils_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ils_pkg::dp_status_type status,
   output ils_pkg::ctl_cmd_type   ctl
);
   ils_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ils_pkg::ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      ctl.op    = ils_pkg::OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ils_pkg::ST_CLEAR: begin
            ctl.op = ils_pkg::OP_CLEAR;
            if (status.clear_done) state_in = ils_pkg::ST_IDLE;
         end
         ils_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = ils_pkg::OP_CAPTURE;
               state_in = ils_pkg::ST_CHECK;
            end
         end
         ils_pkg::ST_CHECK: begin
            ctl.op   = ils_pkg::OP_CHECK;
            state_in = ils_pkg::ST_WALK;
         end
         // the last walk cycle reads everything at the located slot
         ils_pkg::ST_WALK: begin
            if (status.walk_done) begin
               ctl.op   = ils_pkg::OP_ACT_RD;
               state_in = ils_pkg::ST_ACT;
            end else begin
               ctl.op = ils_pkg::OP_WALK_STEP;
            end
         end
         ils_pkg::ST_ACT: begin
            ctl.op   = ils_pkg::OP_ACT;
            state_in = ils_pkg::ST_LINK;
         end
         ils_pkg::ST_LINK: begin
            ctl.op   = ils_pkg::OP_LINK;
            state_in = ils_pkg::ST_RESP;
         end
         ils_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ils_pkg::ST_IDLE;
         end
         default: state_in = ils_pkg::ST_IDLE;
      endcase
   end
endmodule

@@ dv/indexed_list_store_tb.sv @@
// self-checking testbench for the indexed list store
module indexed_list_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 256;
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_cmd;
   logic [8:0] req_position;
   logic signed [31:0] req_data_value;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_ok;
   logic signed [31:0] rsp_read_value;
   logic [8:0] rsp_count;

   typedef struct {
      logic ok;
      logic [31:0] value;
      logic [8:0] count;
   } answer_type;

   // the list is kept as a plain array of values in list order
   logic [31:0] list_model[$];
   answer_type answers_due[$];
   int error_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int idle_cycles = 0;
   bit no_gaps = 0;
   bit rsp_gaps_on = 1;

   indexed_list_store uut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch on %s: got %0h want %0h (word %0d)", what, got, want,
                  words_checked);
   endtask

   function automatic answer_type predict_list(ils_pkg::cmd_type c, int pos, logic [31:0] v);
      answer_type a;
      a.ok = 0;
      a.value = 0;
      case (c)
         ils_pkg::CMD_READ: if (pos < list_model.size()) begin
            a.ok = 1;
            a.value = list_model[pos];
         end
         ils_pkg::CMD_OVERWRITE: if (pos < list_model.size()) begin
            a.ok = 1;
            list_model[pos] = v;
         end
         ils_pkg::CMD_INSERT: if (pos <= list_model.size() && list_model.size() < CAP) begin
            a.ok = 1;
            list_model.insert(pos, v);
         end
         default: if (pos < list_model.size()) begin
            a.ok = 1;
            list_model.delete(pos);
         end
      endcase
      a.count = 9'(list_model.size());
      return a;
   endfunction

   task automatic send_word(input ils_pkg::cmd_type c, input int pos, input logic [31:0] v);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= c;
      req_position <= pos[8:0];
      req_data_value <= v;
      do @(posedge clock); while (!req_ready);
      answers_due.push_back(predict_list(c, pos, v));
      words_sent++;
   endtask

   // response side: random stall bursts, check each word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         answer_type a;
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_count), 32'(0));
         end else begin
            a = answers_due.pop_front();
            if (rsp_ok !== a.ok) report_mismatch("ok", 32'(rsp_ok), 32'(a.ok));
            if (rsp_read_value !== a.value)
               report_mismatch("read_value", rsp_read_value, a.value);
            if (rsp_count !== a.count) report_mismatch("count", 32'(rsp_count), 32'(a.count));
         end
         words_checked++;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (rsp_gaps_on && !no_gaps && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 8);
         rsp_ready <= 0;
      end else rsp_ready <= 1;
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("** indexed_list_store: FAILED **");
         $finish;
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_store();
      send_word(ils_pkg::CMD_READ, 0, 0);
      send_word(ils_pkg::CMD_OVERWRITE, 0, 32'h1234);
      send_word(ils_pkg::CMD_REMOVE, 0, 0);
      send_word(ils_pkg::CMD_INSERT, 1, 5);
      send_word(ils_pkg::CMD_READ, 511, 0);
   endtask

   task automatic test_directed_edges();
      send_word(ils_pkg::CMD_INSERT, 0, 32'h8000_0000);
      send_word(ils_pkg::CMD_INSERT, 1, 32'h7fff_ffff);
      send_word(ils_pkg::CMD_INSERT, 0, 32'hffff_ffff);
      send_word(ils_pkg::CMD_INSERT, 3, 32'h0);
      send_word(ils_pkg::CMD_INSERT, 2, 32'h5a5a_a5a5);
      send_word(ils_pkg::CMD_INSERT, 9, 1);
      for (int i = 0; i < 6; i++) send_word(ils_pkg::CMD_READ, i, 0);
      send_word(ils_pkg::CMD_OVERWRITE, 2, 32'hdead_beef);
      send_word(ils_pkg::CMD_OVERWRITE, 5, 1);
      send_word(ils_pkg::CMD_READ, 2, 0);
      send_word(ils_pkg::CMD_REMOVE, 4, 0);
      send_word(ils_pkg::CMD_REMOVE, 0, 0);
      send_word(ils_pkg::CMD_REMOVE, 1, 0);
      send_word(ils_pkg::CMD_REMOVE, 3, 0);
      send_word(ils_pkg::CMD_READ, 256, 0);
   endtask

   task automatic test_fill_and_drain();
      // fill to capacity, hit full, then drain from both ends
      while (list_model.size() < CAP)
         send_word(ils_pkg::CMD_INSERT, $urandom_range(0, list_model.size()), rand_value());
      send_word(ils_pkg::CMD_INSERT, 0, 7);
      send_word(ils_pkg::CMD_INSERT, CAP, 7);
      send_word(ils_pkg::CMD_READ, CAP - 1, 0);
      send_word(ils_pkg::CMD_READ, 127, 0);
      send_word(ils_pkg::CMD_READ, 128, 0);
      send_word(ils_pkg::CMD_OVERWRITE, 255, 32'h8000_0001);
      send_word(ils_pkg::CMD_READ, 255, 0);
      while (list_model.size() > 0)
         send_word(ils_pkg::CMD_REMOVE, $urandom_range(0, 1) ? 0 : list_model.size() - 1, 0);
   endtask

   task automatic test_random_mix(input int n);
      for (int i = 0; i < n; i++) begin
         int sz, pos;
         ils_pkg::cmd_type c;
         sz = list_model.size();
         c = ils_pkg::cmd_type'($urandom_range(0, 3));
         // grow when small, shrink when near full
         if (sz < 8 && $urandom_range(0, 1)) c = ils_pkg::CMD_INSERT;
         if (sz > 200 && $urandom_range(0, 1)) c = ils_pkg::CMD_REMOVE;
         if ($urandom_range(0, 15) == 0) pos = $urandom_range(sz, 511);
         else pos = $urandom_range(0, (sz == 0) ? 0
                                   : sz - ((c == ils_pkg::CMD_INSERT) ? 0 : 1));
         send_word(c, pos, rand_value());
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_cmd = ils_pkg::CMD_READ;
      req_position = 0;
      req_data_value = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      test_empty_store();
      test_directed_edges();
      test_fill_and_drain();
      test_random_mix(1000);
      no_gaps = 1;
      test_random_mix(300);
      req_valid <= 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d commands across empty, full and random list states", words_sent);
      $display("checked %0d responses, %0d mismatches", words_checked, error_count);
      if (error_count == 0 && answers_due.size() == 0)
         $display("** indexed_list_store: PASSED **");
      else
         $display("** indexed_list_store: FAILED **");
      $finish;
   end
endmodule
